>>> rtl/core/depc_pkg.sv
// Shared types, codes and constants of the debounced edge pulse counter.
package depc_pkg;

    localparam int unsigned TIME_W  = 32;
    localparam int unsigned COUNT_W = 32;
    localparam int unsigned PULSE_W = 31;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [PULSE_W-1:0] PULSE_MAX = {PULSE_W{1'b1}};

    typedef enum logic [2:0] {
        OC_COUNTED    = 3'd0,
        OC_SAME       = 3'd1,
        OC_WRONG_EDGE = 3'd2,
        OC_DEBOUNCED  = 3'd3,
        OC_STARTED    = 3'd4
    } outcome_t;

    localparam logic [1:0] EDGE_FALLING = 2'd0;
    localparam logic [1:0] EDGE_RISING  = 2'd1;
    localparam logic [1:0] EDGE_BOTH    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_HIGH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EDGE_MODE     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_TIME = 2'd2;

    localparam logic KIND_EVENT = 1'b0;
    localparam logic KIND_START = 1'b1;

    typedef struct packed {
        logic              kind;
        logic              pin_level;
        logic [TIME_W-1:0] now_time;
    } req_t;

    typedef struct packed {
        outcome_t           outcome;
        logic               logical_level;
        logic [PULSE_W-1:0] pulse_total;
        logic [TIME_W-1:0]  last_pulse_stamp;
        logic [COUNT_W-1:0] event_total;
        logic [COUNT_W-1:0] transition_total;
        logic [COUNT_W-1:0] same_state_total;
        logic [COUNT_W-1:0] wrong_edge_total;
        logic [COUNT_W-1:0] debounce_total;
    } res_t;

    typedef struct packed {
        logic              active_high;
        logic [1:0]        edge_mode;
        logic [TIME_W-1:0] debounce_time;
    } cfg_t;

endpackage

>>> rtl/core/depc_cfg_regs.sv
// Configuration registers: polarity, edge mode and debounce time.
module depc_cfg_regs
    import depc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [TIME_W-1:0]    cfg_data,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg      = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_ACTIVE_HIGH:   cfg_next.active_high   = cfg_data[0];
                CFG_EDGE_MODE:     cfg_next.edge_mode     = cfg_data[1:0];
                CFG_DEBOUNCE_TIME: cfg_next.debounce_time = cfg_data;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.active_high   <= 1'b1;
            cfg_reg.edge_mode     <= EDGE_RISING;
            cfg_reg.debounce_time <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

>>> rtl/core/depc_step.sv
// Level and counter state with the per-request classification logic.
module depc_step
    import depc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic step_en,
    input  req_t req,
    input  cfg_t cfg,
    output res_t res
);

    logic               level_reg,      level_next;
    logic [PULSE_W-1:0] pulse_reg,      pulse_next;
    logic [TIME_W-1:0]  last_time_reg,  last_time_next;
    logic [COUNT_W-1:0] event_reg,      event_next;
    logic [COUNT_W-1:0] transition_reg, transition_next;
    logic [COUNT_W-1:0] same_reg,       same_next;
    logic [COUNT_W-1:0] wrong_reg,      wrong_next;
    logic [COUNT_W-1:0] debounce_reg,   debounce_next;

    outcome_t          outcome;
    logic              lvl;
    logic              rising;
    logic              qualifies;
    logic [TIME_W-1:0] elapsed;
    logic              too_soon;

    always_comb
    begin
        lvl       = cfg.active_high ? req.pin_level : ~req.pin_level;
        rising    = ~level_reg;
        qualifies = (cfg.edge_mode == EDGE_RISING && rising) ||
                    (cfg.edge_mode == EDGE_FALLING && !rising) ||
                    (cfg.edge_mode == EDGE_BOTH);
        elapsed   = req.now_time - last_time_reg;
        too_soon  = (cfg.debounce_time != '0) && (last_time_reg != '0) &&
                    (elapsed < cfg.debounce_time);

        level_next      = level_reg;
        pulse_next      = pulse_reg;
        last_time_next  = last_time_reg;
        event_next      = event_reg;
        transition_next = transition_reg;
        same_next       = same_reg;
        wrong_next      = wrong_reg;
        debounce_next   = debounce_reg;
        outcome         = OC_SAME;

        if (req.kind == KIND_START)
        begin
            level_next      = lvl;
            pulse_next      = '0;
            last_time_next  = '0;
            event_next      = '0;
            transition_next = '0;
            same_next       = '0;
            wrong_next      = '0;
            debounce_next   = '0;
            outcome         = OC_STARTED;
        end
        else
        begin
            event_next = event_reg + 1'b1;
            priority if (lvl == level_reg)
            begin
                same_next = same_reg + 1'b1;
                outcome   = OC_SAME;
            end
            else if (!qualifies)
            begin
                level_next      = lvl;
                transition_next = transition_reg + 1'b1;
                wrong_next      = wrong_reg + 1'b1;
                outcome         = OC_WRONG_EDGE;
            end
            else if (too_soon)
            begin
                level_next      = lvl;
                transition_next = transition_reg + 1'b1;
                debounce_next   = debounce_reg + 1'b1;
                outcome         = OC_DEBOUNCED;
            end
            else
            begin
                level_next      = lvl;
                transition_next = transition_reg + 1'b1;
                if (pulse_reg != PULSE_MAX)
                begin
                    pulse_next = pulse_reg + 1'b1;
                end
                last_time_next = req.now_time;
                outcome        = OC_COUNTED;
            end
        end

        res.outcome          = outcome;
        res.logical_level    = level_next;
        res.pulse_total      = pulse_next;
        res.last_pulse_stamp = last_time_next;
        res.event_total      = event_next;
        res.transition_total = transition_next;
        res.same_state_total = same_next;
        res.wrong_edge_total = wrong_next;
        res.debounce_total   = debounce_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg      <= 1'b0;
            pulse_reg      <= '0;
            last_time_reg  <= '0;
            event_reg      <= '0;
            transition_reg <= '0;
            same_reg       <= '0;
            wrong_reg      <= '0;
            debounce_reg   <= '0;
        end
        else if (step_en)
        begin
            level_reg      <= level_next;
            pulse_reg      <= pulse_next;
            last_time_reg  <= last_time_next;
            event_reg      <= event_next;
            transition_reg <= transition_next;
            same_reg       <= same_next;
            wrong_reg      <= wrong_next;
            debounce_reg   <= debounce_next;
        end
    end

endmodule

>>> rtl/core/debounced_edge_pulse_counter_core.sv
// Top level of the debounced edge pulse counter: request and result registers.
//
// Usage:
//   Request channel (req_valid, req_stall, req_data): each request is a pin
//   change event or a start request. A request is taken at a clock edge with
//   req_valid high and req_stall low.
//   Result channel (res_valid, res_stall, res_data): exactly one result per
//   request, in request order, taken when res_valid is high and res_stall low.
//   Configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data): always
//   ready; write only while no request is in flight.
// Path: a taken request is held in the request register; its result is loaded
//   into the result register once res_stall does not hold the result there.
// Throughput: one request per cycle unless stalled; the level and counter update
//   is a single pass of compare and increment logic between the two registers.
// Reset: all counters, the stored level and both stage valids clear; polarity
//   resets to active high, edge mode to rising, debounce time to zero.
// Stall: while res_stall holds a result, one more request waits in the
//   request register; req_stall rises only when both stages are full.
module debounced_edge_pulse_counter_core
    import depc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_stall,
    input  req_t                 req_data,
    output logic                 res_valid,
    input  logic                 res_stall,
    output res_t                 res_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [TIME_W-1:0]    cfg_data
);

    cfg_t cfg;
    res_t step_res;

    logic s1_valid_reg, s1_valid_next;
    req_t s1_req_reg;
    logic res_valid_reg, res_valid_next;
    res_t res_reg;

    logic take;
    logic req_take;
    logic step_en;

    assign take      = !res_valid_reg || !res_stall;
    assign req_stall = s1_valid_reg && !take;
    assign req_take  = req_valid && !req_stall;
    assign step_en   = s1_valid_reg && take;

    assign res_valid = res_valid_reg;
    assign res_data  = res_reg;

    depc_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    depc_step u_step
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (step_en),
        .req     (s1_req_reg),
        .cfg     (cfg),
        .res     (step_res)
    );

    always_comb
    begin
        s1_valid_next  = req_take ? 1'b1 : (take ? 1'b0 : s1_valid_reg);
        res_valid_next = take ? s1_valid_reg : res_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            s1_req_reg <= req_data;
        end
        if (step_en)
        begin
            res_reg <= step_res;
        end
    end

    a_start_clears : assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.outcome == OC_STARTED |->
            res_data.pulse_total == '0 && res_data.last_pulse_stamp == '0 &&
            res_data.event_total == '0 && res_data.debounce_total == '0)
        else $error("start result with nonzero counters");

    a_event_sum : assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |->
            res_data.event_total ==
            COUNT_W'(res_data.transition_total + res_data.same_state_total))
        else $error("event count differs from transitions plus same-state");

    a_stall_cause : assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> s1_valid_reg && res_valid_reg && res_stall)
        else $error("request stalled with a free stage");

    a_step_loads : assert property (@(posedge clk) disable iff (!rst_n)
        step_en |=> res_valid_reg)
        else $error("advanced request lost its result");

endmodule

>>> verif/testbench.sv
// Self-checking testbench for the debounced edge pulse counter core.
`timescale 1ns / 1ps

module testbench;
    import depc_pkg::*;

    localparam logic [1:0] EDGE_NONE = 2'd3;
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned HOLDOFF_CYCLES = 80;

    logic                 clk;
    logic                 rst_n;
    logic                 req_valid;
    logic                 req_stall;
    req_t                 req_data;
    logic                 res_valid;
    logic                 res_stall;
    res_t                 res_data;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [TIME_W-1:0]    cfg_data;

    logic               mirror_active_high = 1'b1;
    logic [1:0]         mirror_edge_mode = EDGE_RISING;
    logic [TIME_W-1:0]  mirror_debounce = '0;

    logic               held_level = 1'b0;
    logic [PULSE_W-1:0] pulse_count = '0;
    logic [TIME_W-1:0]  last_stamp = '0;
    logic [COUNT_W-1:0] event_count = '0;
    logic [COUNT_W-1:0] transition_count = '0;
    logic [COUNT_W-1:0] same_count = '0;
    logic [COUNT_W-1:0] wrong_edge_count = '0;
    logic [COUNT_W-1:0] bounce_count = '0;

    res_t              pending_snapshots[$];
    int                fail_count = 0;
    int unsigned       cycle_count = 0;
    int                send_idle_pct = 0;
    int                stall_pct = 0;
    logic              holding = 1'b0;
    logic [TIME_W-1:0] stamp_clock = '0;

    debounced_edge_pulse_counter_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Regression FAIL");
        $finish;
    end

    function automatic res_t predict_pin_item(input req_t item);
        res_t              snap;
        logic              lvl;
        logic              rising;
        logic              qualifies;
        logic [TIME_W-1:0] elapsed;
        outcome_t          oc;
        lvl = mirror_active_high ? item.pin_level : ~item.pin_level;
        if (item.kind == KIND_START)
        begin
            held_level = lvl;
            pulse_count = '0;
            last_stamp = '0;
            event_count = '0;
            transition_count = '0;
            same_count = '0;
            wrong_edge_count = '0;
            bounce_count = '0;
            oc = OC_STARTED;
        end
        else
        begin
            event_count = event_count + 1'b1;
            if (lvl == held_level)
            begin
                same_count = same_count + 1'b1;
                oc = OC_SAME;
            end
            else
            begin
                rising = ~held_level;
                held_level = lvl;
                transition_count = transition_count + 1'b1;
                qualifies = (mirror_edge_mode == EDGE_RISING && rising) ||
                            (mirror_edge_mode == EDGE_FALLING && !rising) ||
                            (mirror_edge_mode == EDGE_BOTH);
                elapsed = item.now_time - last_stamp;
                if (!qualifies)
                begin
                    wrong_edge_count = wrong_edge_count + 1'b1;
                    oc = OC_WRONG_EDGE;
                end
                else if (mirror_debounce != '0 && last_stamp != '0 &&
                         elapsed < mirror_debounce)
                begin
                    bounce_count = bounce_count + 1'b1;
                    oc = OC_DEBOUNCED;
                end
                else
                begin
                    if (pulse_count != PULSE_MAX)
                        pulse_count = pulse_count + 1'b1;
                    last_stamp = item.now_time;
                    oc = OC_COUNTED;
                end
            end
        end
        snap.outcome = oc;
        snap.logical_level = held_level;
        snap.pulse_total = pulse_count;
        snap.last_pulse_stamp = last_stamp;
        snap.event_total = event_count;
        snap.transition_total = transition_count;
        snap.same_state_total = same_count;
        snap.wrong_edge_total = wrong_edge_count;
        snap.debounce_total = bounce_count;
        return snap;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    task automatic check_result(input res_t got);
        res_t want;
        if (pending_snapshots.size() == 0)
        begin
            $error("result with no request outstanding");
            fail_count++;
        end
        else
        begin
            want = pending_snapshots.pop_front();
            check_field("outcome", 32'(want.outcome), 32'(got.outcome));
            check_field("logical_level", 32'(want.logical_level), 32'(got.logical_level));
            check_field("pulse_total", 32'(want.pulse_total), 32'(got.pulse_total));
            check_field("last_pulse_stamp", want.last_pulse_stamp, got.last_pulse_stamp);
            check_field("event_total", want.event_total, got.event_total);
            check_field("transition_total", want.transition_total, got.transition_total);
            check_field("same_state_total", want.same_state_total, got.same_state_total);
            check_field("wrong_edge_total", want.wrong_edge_total, got.wrong_edge_total);
            check_field("debounce_total", want.debounce_total, got.debounce_total);
        end
    endtask

    initial
    begin
        res_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && res_valid && !res_stall)
                check_result(res_data);
            res_stall <= holding || ($urandom_range(99) < stall_pct);
        end
    end

    task automatic send_request(input logic kind, input logic pin,
                                input logic [TIME_W-1:0] stamp);
        req_t item;
        item.kind = kind;
        item.pin_level = pin;
        item.now_time = stamp;
        req_valid <= 1'b1;
        req_data <= item;
        do @(posedge clk); while (req_stall);
        pending_snapshots.push_back(predict_pin_item(item));
        if ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [TIME_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        case (index)
            CFG_ACTIVE_HIGH:   mirror_active_high = value[0];
            CFG_EDGE_MODE:     mirror_edge_mode = value[1:0];
            CFG_DEBOUNCE_TIME: mirror_debounce = value;
            default:           ;
        endcase
    endtask

    task automatic configure(input logic polarity, input logic [1:0] mode,
                             input logic [TIME_W-1:0] window);
        write_register(CFG_ACTIVE_HIGH, 32'(polarity));
        write_register(CFG_EDGE_MODE, 32'(mode));
        write_register(CFG_DEBOUNCE_TIME, window);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain_and_settle();
        req_valid <= 1'b0;
        while (pending_snapshots.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic test_reset_defaults();
        send_request(KIND_EVENT, 1'b0, 32'd100);
        send_request(KIND_EVENT, 1'b1, 32'd0);
        send_request(KIND_EVENT, 1'b0, 32'd5);
        send_request(KIND_EVENT, 1'b1, 32'hFFFF_FFFF);
        drain_and_settle();
    endtask

    task automatic test_debounce_window();
        configure(1'b1, EDGE_BOTH, 32'd100);
        send_request(KIND_START, 1'b0, 32'hFFFF_FFFF);
        send_request(KIND_EVENT, 1'b1, 32'd1000);
        send_request(KIND_EVENT, 1'b0, 32'd1050);
        send_request(KIND_EVENT, 1'b1, 32'd1099);
        send_request(KIND_EVENT, 1'b0, 32'd1100);
        send_request(KIND_EVENT, 1'b1, 32'hFFFF_FFF0);
        send_request(KIND_EVENT, 1'b0, 32'h0000_0010);
        send_request(KIND_EVENT, 1'b1, 32'h0000_0060);
        drain_and_settle();
    endtask

    task automatic test_debounce_extremes();
        configure(1'b1, EDGE_BOTH, 32'hFFFF_FFFF);
        send_request(KIND_START, 1'b0, 32'd0);
        send_request(KIND_EVENT, 1'b1, 32'd5);
        send_request(KIND_EVENT, 1'b0, 32'd6);
        send_request(KIND_EVENT, 1'b1, 32'd4);
        drain_and_settle();
        configure(1'b1, EDGE_BOTH, 32'd50);
        send_request(KIND_START, 1'b0, 32'd77);
        send_request(KIND_EVENT, 1'b1, 32'd0);
        send_request(KIND_EVENT, 1'b0, 32'd1);
        drain_and_settle();
    endtask

    task automatic test_polarity_and_edge_modes();
        configure(1'b0, EDGE_FALLING, 32'd0);
        send_request(KIND_START, 1'b1, 32'd3);
        send_request(KIND_EVENT, 1'b0, 32'd10);
        send_request(KIND_EVENT, 1'b1, 32'd20);
        send_request(KIND_EVENT, 1'b1, 32'd30);
        drain_and_settle();
        configure(1'b0, EDGE_NONE, 32'd0);
        send_request(KIND_EVENT, 1'b0, 32'd40);
        send_request(KIND_EVENT, 1'b1, 32'd50);
        drain_and_settle();
    endtask

    task automatic test_backpressure();
        configure(1'b1, EDGE_BOTH, 32'd0);
        send_idle_pct = 0;
        stall_pct = 0;
        fork
            begin
                holding <= 1'b1;
                repeat (HOLDOFF_CYCLES) @(posedge clk);
                holding <= 1'b0;
            end
        join_none
        for (int i = 0; i < 12; i++)
            send_request(i == 0 ? KIND_START : KIND_EVENT, i[0], 32'(i * 7 + 1));
        drain_and_settle();
    endtask

    task automatic run_phase(input logic polarity, input logic [1:0] mode,
                             input logic [TIME_W-1:0] window,
                             input logic [TIME_W-1:0] spread,
                             input int send_pct, input int stall_in, input int count);
        logic              kind;
        logic [TIME_W-1:0] stamp;
        configure(polarity, mode, window);
        send_idle_pct = send_pct;
        stall_pct = stall_in;
        for (int i = 0; i < count; i++)
        begin
            kind = ($urandom_range(99) < 5) ? KIND_START : KIND_EVENT;
            if ($urandom_range(99) < 10)
                stamp = $urandom;
            else
            begin
                stamp_clock = stamp_clock + $urandom_range(spread);
                stamp = stamp_clock;
            end
            send_request(kind, 1'($urandom_range(1)), stamp);
        end
        drain_and_settle();
        send_idle_pct = 0;
        stall_pct = 0;
    endtask

    task automatic test_random_traffic();
        stamp_clock = $urandom;
        run_phase(1'b1, EDGE_RISING,  32'd0,         32'd50,  0,  0,  46);
        run_phase(1'b0, EDGE_FALLING, 32'd37,        32'd80,  0,  0,  46);
        run_phase(1'b1, EDGE_BOTH,    32'd1,         32'd3,   0,  0,  46);
        run_phase(1'b0, EDGE_BOTH,    32'd120,       32'd300, 54, 0,  46);
        run_phase(1'b1, EDGE_NONE,    32'd10,        32'd30,  54, 0,  46);
        run_phase(1'b1, EDGE_BOTH,    32'hFFFF_FFFF, $urandom, 54, 0, 46);
        run_phase(1'b0, EDGE_RISING,  $urandom,      32'hFFFF_FFFF, 0, 54, 46);
        run_phase(1'b1, EDGE_FALLING, 32'd200,       32'd500, 0,  54, 46);
        run_phase(1'b0, EDGE_BOTH,    32'd5,         32'd12,  0,  54, 46);
        run_phase(1'b1, EDGE_BOTH,    32'd64,        32'd160, 29, 29, 46);
        run_phase(1'b0, EDGE_RISING,  32'd0,         32'd9,   29, 29, 46);
        run_phase(1'b1, EDGE_FALLING, 32'd2,         32'd6,   29, 29, 46);
    endtask

    initial
    begin
        rst_n = 1'b0;
        req_valid = 1'b0;
        req_data = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_debounce_window();
        test_debounce_extremes();
        test_polarity_and_edge_modes();
        test_backpressure();
        test_random_traffic();
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

>>> sim.f
rtl/core/depc_pkg.sv
rtl/core/depc_cfg_regs.sv
rtl/core/depc_step.sv
rtl/core/debounced_edge_pulse_counter_core.sv
verif/testbench.sv
